FILE: rtl/dtsd_pkg.sv
// Shared types and constants of the dual tachometer with stall detection.
// Used by the stream interface instances and the top level; no dependencies.
package dtsd_pkg;

  // Default ring depth (one count per second of window)
  localparam int unsigned WINDOW_DEF = 10;

  // Stall time after reset, in milliseconds
  localparam logic [15:0] STALL_TIME_RST = 16'd5000;

  // Speed codes
  localparam logic signed [15:0] SPEED_MAX   = 16'sd32767;
  localparam logic signed [15:0] SPEED_FAULT = -16'sd1;
  localparam logic signed [15:0] SPEED_ZERO  = 16'sd0;

  // Minutes to seconds
  localparam int unsigned SEC_PER_MIN = 60;

  // One tick beat: pulse counts and motor status of both channels
  typedef struct packed {
    logic [15:0] pulses_a;
    logic [15:0] pulses_b;
    logic        driven_a;
    logic        driven_b;
    logic [31:0] move_age_a;
    logic [31:0] move_age_b;
    logic        cleaning_a;
    logic        cleaning_b;
    logic        clear_fault_a;
    logic        clear_fault_b;
  } tick_t;

  // One report beat: speeds and abort requests
  typedef struct packed {
    logic signed [15:0] speed_a;
    logic signed [15:0] speed_b;
    logic               abort_cleaning_a;
    logic               abort_cleaning_b;
  } report_t;

endpackage

FILE: rtl/dtsd_stream_if.sv
// Valid/ready stream interface carrying one payload beat per handshake.
// Payload type is a parameter; no package dependency.
interface dtsd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/dual_tachometer_stall_detect_unit.sv
// A tick beat is accepted into the input register, and its report beat is then held
//   in the result register; throughput one tick per cycle while report_o is ready.
// The rate is set by the ring update and speed multiply per channel, both done combinationally.
// Reset clears sums, slot, stall faults, ring valid bits and the handshake state;
//   the stall time register returns to 5000 ms. No clearing pass is needed.
// Depends on dtsd_pkg and dtsd_stream_if.
module dual_tachometer_stall_detect_unit #(
  parameter int unsigned WINDOW = dtsd_pkg::WINDOW_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i,
  dtsd_stream_if.sink          tick_i,
  dtsd_stream_if.source        report_o
);
  import dtsd_pkg::*;

  // Derived widths and constants
  localparam int unsigned SLOT_W  = $clog2(WINDOW);
  localparam int unsigned SUM_W   = 16 + $clog2(WINDOW);
  // rpm = floor(sum*60/WINDOW) by reciprocal multiply, exact for sum*60 < 2^DIV_N
  localparam int unsigned DIV_N   = 15 + $clog2(WINDOW);
  localparam int unsigned DIV_S   = DIV_N + $clog2(WINDOW);
  localparam longint unsigned DIV_M   = ((64'd1 << DIV_S) + WINDOW - 1) / WINDOW;
  localparam longint unsigned RPM_K   = SEC_PER_MIN * DIV_M;
  // Smallest sum whose rpm exceeds the positive speed range
  localparam int unsigned SAT_SUM = (32768 * WINDOW + SEC_PER_MIN - 1) / SEC_PER_MIN;
  localparam int unsigned MUL_W   = $clog2(SAT_SUM);
  localparam int unsigned K_W     = $clog2(RPM_K + 1);
  localparam int unsigned PROD_W  = MUL_W + K_W;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic               stalled;
    logic               abort_req;
    logic signed [15:0] speed;
  } chan_res_t;

  // Per-channel update: ring sum, stall latch, speed code
  function automatic chan_res_t chan_eval(
    input logic [SUM_W-1:0] sum_q,
    input logic [15:0]      old_cnt,
    input logic [15:0]      pulses,
    input logic             stalled_q,
    input logic             clear,
    input logic             driven,
    input logic [31:0]      age,
    input logic             cleaning,
    input logic [15:0]      stall_time
  );
    chan_res_t          r;
    logic               kept;
    logic               has_pulses;
    logic               new_stall;
    logic [SUM_W-1:0]   s;
    logic [PROD_W-1:0]  prod;
    kept       = stalled_q & ~clear;
    s          = sum_q - SUM_W'(old_cnt) + SUM_W'(pulses);
    has_pulses = (pulses != 16'd0);
    new_stall  = ~kept & ~has_pulses & driven & (age > 32'(stall_time));
    prod       = PROD_W'(s[MUL_W-1:0]) * PROD_W'(K_W'(RPM_K));
    r.sum       = s;
    r.stalled   = kept | new_stall;
    r.abort_req = new_stall & cleaning;
    if (r.stalled) begin
      r.speed = SPEED_FAULT;
    end else if (!has_pulses) begin
      r.speed = SPEED_ZERO;
    end else if (s >= SUM_W'(SAT_SUM)) begin
      r.speed = SPEED_MAX;
    end else begin
      r.speed = {1'b0, prod[DIV_S +: 15]};
    end
    return r;
  endfunction

  // Handshake state
  logic        in_vld_q;
  tick_t       in_q;
  logic        out_vld_q;
  report_t     out_q;
  logic        advance;

  // Block state
  logic [15:0]       stall_time_q;
  logic [SUM_W-1:0]  sum_a_q, sum_b_q;
  logic              stalled_a_q, stalled_b_q;
  logic [SLOT_W-1:0] slot_q, slot_nxt, rd_addr;
  logic [WINDOW-1:0] ring_vld_q;
  logic              rd_vld_q;
  logic [15:0]       ring_a_q [WINDOW];
  logic [15:0]       ring_b_q [WINDOW];
  logic [15:0]       ring_a_rd_q, ring_b_rd_q;
  logic [15:0]       old_a, old_b;
  chan_res_t         res_a, res_b;

  // Beat moves from input register to result register
  assign advance      = in_vld_q & (~out_vld_q | report_o.ready);
  assign tick_i.ready = ~in_vld_q | advance;

  assign report_o.valid   = out_vld_q;
  assign report_o.payload = out_q;

  // Slot pointer and prefetch address of the ring entry to retire next
  assign slot_nxt = (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);
  assign rd_addr  = advance ? slot_nxt : slot_q;

  // Entries never written read as zero
  assign old_a = rd_vld_q ? ring_a_rd_q : 16'd0;
  assign old_b = rd_vld_q ? ring_b_rd_q : 16'd0;

  // Channel evaluation
  always_comb begin
    res_a = chan_eval(sum_a_q, old_a, in_q.pulses_a, stalled_a_q, in_q.clear_fault_a,
                      in_q.driven_a, in_q.move_age_a, in_q.cleaning_a, stall_time_q);
    res_b = chan_eval(sum_b_q, old_b, in_q.pulses_b, stalled_b_q, in_q.clear_fault_b,
                      in_q.driven_b, in_q.move_age_b, in_q.cleaning_b, stall_time_q);
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_time_q <= STALL_TIME_RST;
    end else if (cfg_we_i) begin
      stall_time_q <= cfg_wdata_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (tick_i.ready) begin
      in_vld_q <= tick_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_i.valid && tick_i.ready) begin
      in_q <= tick_i.payload;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (report_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.speed_a          <= res_a.speed;
      out_q.speed_b          <= res_b.speed;
      out_q.abort_cleaning_a <= res_a.abort_req;
      out_q.abort_cleaning_b <= res_b.abort_req;
    end
  end

  // Channel state: sums, faults, slot, ring valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_a_q     <= '0;
      sum_b_q     <= '0;
      stalled_a_q <= 1'b0;
      stalled_b_q <= 1'b0;
      slot_q      <= '0;
      ring_vld_q  <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      if (advance) begin
        sum_a_q             <= res_a.sum;
        sum_b_q             <= res_b.sum;
        stalled_a_q         <= res_a.stalled;
        stalled_b_q         <= res_b.stalled;
        slot_q              <= slot_nxt;
        ring_vld_q[slot_q]  <= 1'b1;
      end
      rd_vld_q <= ring_vld_q[rd_addr];
    end
  end

  // Ring memories: write retiring slot, read next slot registered
  always_ff @(posedge clk_i) begin
    if (advance) begin
      ring_a_q[slot_q] <= in_q.pulses_a;
      ring_b_q[slot_q] <= in_q.pulses_b;
    end
    ring_a_rd_q <= ring_a_q[rd_addr];
    ring_b_rd_q <= ring_b_q[rd_addr];
  end

  // Checks
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SLOT_LAST)
    else $error("slot pointer out of window");

  a_abort_fault_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.abort_cleaning_a) |-> (out_q.speed_a == SPEED_FAULT))
    else $error("abort request on channel a without fault code");

  a_abort_fault_b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.abort_cleaning_b) |-> (out_q.speed_b == SPEED_FAULT))
    else $error("abort request on channel b without fault code");

  a_ring_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> ring_vld_q[$past(slot_q)])
    else $error("ring entry not marked valid after write");

  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sum_a_q <= SUM_W'(WINDOW * 65535)) && (sum_b_q <= SUM_W'(WINDOW * 65535)))
    else $error("window sum exceeds ring capacity");

endmodule

FILE: tb/tb.sv
// Self-checking testbench of the dual tachometer with stall detection.
// Needs dtsd_pkg, dtsd_stream_if and dual_tachometer_stall_detect_unit; predicts each
// report beat from its own ring/sum/fault model and compares every field.
`timescale 1ns / 100ps

module tb;
  import dtsd_pkg::*;

  localparam int unsigned WINDOW         = WINDOW_DEF;
  localparam int unsigned RANDOM_PER_SET = 172;
  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef enum logic [1:0] {RDY_OPEN, RDY_COIN, RDY_CHOKE} ready_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  dtsd_stream_if #(.T(tick_t))   tick_if ();
  dtsd_stream_if #(.T(report_t)) report_if ();

  dual_tachometer_stall_detect_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .tick_i      (tick_if),
    .report_o    (report_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Tachometer model state: per-channel ring, running sum and fault latch
  logic [15:0] pulse_ring [2][WINDOW];
  logic [19:0] pulse_sum  [2];
  logic        stall_latched [2];
  int unsigned ring_slot;
  logic [15:0] stall_ms;

  tick_t   pending_ticks [$];
  report_t expected_reports [$];
  int      err_count = 0;

  // Driver and monitor bookkeeping
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  logic        send_beat;
  int unsigned mode_left  = 0;
  ready_mode_e rdy_mode   = RDY_OPEN;
  int unsigned idle_cycles = 0;
  report_t     got_report;
  report_t     want_report;

  function automatic void clear_tach_model();
    for (int c = 0; c < 2; c++) begin
      for (int i = 0; i < WINDOW; i++) pulse_ring[c][i] = '0;
      pulse_sum[c]     = '0;
      stall_latched[c] = 1'b0;
    end
    ring_slot = 0;
    stall_ms  = STALL_TIME_RST;
  endfunction

  // Advance the model by one tick and return the report it should cause
  function automatic report_t predict_report(tick_t t);
    logic [15:0]        pulses [2];
    logic               driven [2];
    logic [31:0]        age    [2];
    logic               cln    [2];
    logic               clr    [2];
    logic signed [15:0] speed  [2];
    logic               abort_req [2];
    int unsigned        rpm;
    report_t            r;
    pulses[0] = t.pulses_a;      pulses[1] = t.pulses_b;
    driven[0] = t.driven_a;      driven[1] = t.driven_b;
    age[0]    = t.move_age_a;    age[1]    = t.move_age_b;
    cln[0]    = t.cleaning_a;    cln[1]    = t.cleaning_b;
    clr[0]    = t.clear_fault_a; clr[1]    = t.clear_fault_b;
    for (int c = 0; c < 2; c++) begin
      abort_req[c] = 1'b0;
      // clear acts before this tick is judged
      if (clr[c]) stall_latched[c] = 1'b0;
      // sum tracks the ring even while faulted
      pulse_sum[c] = pulse_sum[c] - 20'(pulse_ring[c][ring_slot]) + 20'(pulses[c]);
      pulse_ring[c][ring_slot] = pulses[c];
      if (!stall_latched[c] && pulses[c] == 16'd0 && driven[c] &&
          age[c] > {16'd0, stall_ms}) begin
        stall_latched[c] = 1'b1;
        abort_req[c]     = cln[c];
      end
      if (stall_latched[c]) begin
        speed[c] = SPEED_FAULT;
      end else if (pulses[c] == 16'd0) begin
        speed[c] = SPEED_ZERO;
      end else begin
        rpm = (int'(pulse_sum[c]) * SEC_PER_MIN) / WINDOW;
        speed[c] = (rpm > 32767) ? SPEED_MAX : 16'(rpm);
      end
    end
    ring_slot = (ring_slot == WINDOW - 1) ? 0 : ring_slot + 1;
    r.speed_a          = speed[0];
    r.speed_b          = speed[1];
    r.abort_cleaning_a = abort_req[0];
    r.abort_cleaning_b = abort_req[1];
    return r;
  endfunction

  function automatic tick_t pack_tick(logic [15:0] pa, logic [15:0] pb, logic da, logic db,
                                      logic [31:0] aa, logic [31:0] ab, logic ca, logic cb,
                                      logic xa, logic xb);
    tick_t t;
    t.pulses_a      = pa;  t.pulses_b      = pb;
    t.driven_a      = da;  t.driven_b      = db;
    t.move_age_a    = aa;  t.move_age_b    = ab;
    t.cleaning_a    = ca;  t.cleaning_b    = cb;
    t.clear_fault_a = xa;  t.clear_fault_b = xb;
    return t;
  endfunction

  // One channel's random content, biased toward the stall boundary
  function automatic void rand_channel(output logic [15:0] pulses, output logic driven,
                                       output logic [31:0] age, output logic cln,
                                       output logic clr);
    case ($urandom_range(0, 9))
      0, 1, 2: pulses = 16'd0;
      3, 4, 5: pulses = 16'($urandom_range(1, 200));
      6, 7:    pulses = 16'($urandom_range(200, 6000));
      default: pulses = 16'($urandom);
    endcase
    driven = ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 4))
      0:       age = {16'd0, stall_ms} + 32'($urandom_range(0, 2)) - 32'd1;
      1:       age = $urandom_range(0, stall_ms);
      2:       age = {16'd0, stall_ms} + $urandom_range(1, 1000);
      default: age = $urandom;
    endcase
    cln = 1'($urandom_range(0, 1));
    clr = ($urandom_range(0, 4) == 0);
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    rand_channel(t.pulses_a, t.driven_a, t.move_age_a, t.cleaning_a, t.clear_fault_a);
    rand_channel(t.pulses_b, t.driven_b, t.move_age_b, t.cleaning_b, t.clear_fault_b);
    return t;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  task automatic wait_drained();
    while (pending_ticks.size() != 0 || expected_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_stall_time(logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    stall_ms     = value;
  endtask

  // Tick driver: bursts with random gaps, valid held until the beat is taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      tick_if.valid <= 1'b0;
    end else begin
      if (tick_if.valid && tick_if.ready)
        expected_reports.push_back(predict_report(pending_ticks.pop_front()));
      send_beat = 1'b0;
      if (tick_if.valid && !tick_if.ready) begin
        send_beat = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (pending_ticks.size() != 0) begin
        send_beat = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      tick_if.valid <= send_beat;
      if (send_beat) tick_if.payload <= pending_ticks[0];
    end
  end

  // Report monitor: compare against the oldest prediction, stall on its own pattern
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      report_if.ready <= 1'b0;
    end else begin
      if (report_if.valid && report_if.ready) begin
        got_report = report_if.payload;
        if (expected_reports.size() == 0) begin
          $error("report beat with no tick waiting: speed_a %0d speed_b %0d",
                 got_report.speed_a, got_report.speed_b);
          err_count++;
        end else begin
          want_report = expected_reports.pop_front();
          check_field("speed_a", want_report.speed_a, got_report.speed_a);
          check_field("speed_b", want_report.speed_b, got_report.speed_b);
          check_field("abort_cleaning_a", want_report.abort_cleaning_a,
                      got_report.abort_cleaning_a);
          check_field("abort_cleaning_b", want_report.abort_cleaning_b,
                      got_report.abort_cleaning_b);
        end
      end

      // watchdog on cycles with no beat on either side
      if ((tick_if.valid && tick_if.ready) || (report_if.valid && report_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end

      if (mode_left == 0) begin
        rdy_mode  = ready_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(1, 40);
      end else begin
        mode_left--;
      end
      case (rdy_mode)
        RDY_OPEN: report_if.ready <= 1'b1;
        RDY_COIN: report_if.ready <= 1'($urandom_range(0, 1));
        default:  report_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Stimulus: directed ticks at the reset stall time, then random sets per setting
  initial begin
    logic [15:0] stall_plan [5];
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    tick_if.valid   = 1'b0;
    tick_if.payload = '0;
    report_if.ready = 1'b0;
    clear_tach_model();
    stall_plan[0] = 16'd0;
    stall_plan[1] = 16'hFFFF;
    stall_plan[2] = 16'd1;
    stall_plan[3] = 16'($urandom_range(2, 65534));
    stall_plan[4] = STALL_TIME_RST;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // idle, small counts, saturation
    pending_ticks.push_back(pack_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_ticks.push_back(pack_tick(1, 2, 1, 1, 0, 0, 0, 0, 0, 0));
    pending_ticks.push_back(pack_tick(16'hFFFF, 16'hFFFF, 1, 1, 0, 0, 0, 0, 0, 0));
    // age equal to the stall time does not fault
    pending_ticks.push_back(pack_tick(0, 0, 1, 1, 5000, 5000, 1, 1, 0, 0));
    // fault on both, abort only where cleaning
    pending_ticks.push_back(pack_tick(0, 0, 1, 1, 5001, 32'hFFFF_FFFF, 1, 0, 0, 0));
    // faulted channels report fault even with pulses, no new abort
    pending_ticks.push_back(pack_tick(100, 100, 1, 1, 0, 0, 1, 1, 0, 0));
    pending_ticks.push_back(pack_tick(0, 0, 1, 1, 6000, 6000, 1, 1, 0, 0));
    // clear and stall together re-latch on a; b clears and runs again
    pending_ticks.push_back(pack_tick(0, 50, 1, 1, 6000, 0, 1, 0, 1, 1));
    // clear a into normal speed; clear b without a fault
    pending_ticks.push_back(pack_tick(7, 0, 0, 1, 6000, 100, 0, 1, 1, 1));
    // fault without cleaning; undriven motor never faults
    pending_ticks.push_back(pack_tick(0, 0, 1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1, 0, 0));
    pending_ticks.push_back(pack_tick(3, 0, 0, 0, 0, 0, 0, 0, 1, 0));
    // wrap the ring with large counts and alternating bit patterns
    pending_ticks.push_back(pack_tick(16'h5555, 16'hAAAA, 1, 1, 32'h5555_5555,
                                      32'hAAAA_AAAA, 1, 1, 0, 0));
    pending_ticks.push_back(pack_tick(16'hAAAA, 16'h5555, 1, 1, 32'hAAAA_AAAA,
                                      32'h5555_5555, 0, 0, 0, 0));
    for (int i = 0; i < 8; i++)
      pending_ticks.push_back(pack_tick(16'hFFFF, 16'(i + 1), 1, 1, 0, 0, 0, 0, 0, 0));
    pending_ticks.push_back(pack_tick(1, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    wait_drained();

    for (int set_idx = 0; set_idx <= 5; set_idx++) begin
      if (set_idx > 0) write_stall_time(stall_plan[set_idx - 1]);
      for (int i = 0; i < RANDOM_PER_SET; i++) pending_ticks.push_back(rand_tick());
      wait_drained();
    end

    if (expected_reports.size() != 0) begin
      $error("%0d predicted reports never arrived", expected_reports.size());
      err_count++;
    end
    if (err_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
